// ===== rtl/elliptic_curve_point_search_macros.svh =====
// ---------------------------------------------------------------------------
// elliptic curve point search assertion macros
// concurrent check helpers, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ELLIPTIC_CURVE_POINT_SEARCH_MACROS_SVH
`define ELLIPTIC_CURVE_POINT_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ECPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define ECPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ECPS_ASSERT_IMP(lbl, ante, cons, msg)
`define ECPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/ecps_pkg.sv =====
// ---------------------------------------------------------------------------
// ecps_pkg
// shared constants for the elliptic curve point search block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecps_pkg;

  // default field width
  localparam int FIELD_BITS_DEF = 17;

  // prime after reset, truncated to the field width
  localparam int PRIME_RESET = 65537;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME   = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/elliptic_curve_point_search.sv =====
// ---------------------------------------------------------------------------
// elliptic curve point search
// finds the points (x, y) of y^2 = x^3 + a*x + b mod p, one x per item
// ---------------------------------------------------------------------------
// Each input item carries one x. The block reduces x, a and b mod p, forms
// r = x^3 + a*x + b mod p and walks y = 0, 1, ... until y*y mod p equals r.
// A hit gives the point (x, y) and, when p - y differs from y, the point
// (x, p - y) as well; tlast marks the final point of the item. An x without
// a root, or a modulus of zero, gives no point. Every point carries a running
// index that tuser = 1 on an input item clears. All modular arithmetic goes
// through one shared double-and-add unit, one bit of the multiplier operand
// per cycle. An item runs the reductions and products first, then tries one
// y candidate per cycle (up to p), then sends one point per cycle while the
// output register is free. in_tready is high only while no item is in work;
// a finished point waits in the output register so the next item can start
// meanwhile. Configuration is written through cfg_we / cfg_index / cfg_wdata;
// the user must write it only while idle, the block does not enforce this.
// Index 0 is a, 1 is b, 2 is p (reset 65537); other indexes are ignored.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "elliptic_curve_point_search_macros.svh"

module elliptic_curve_point_search #(
  parameter int FIELD_BITS = ecps_pkg::FIELD_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input items
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [((FIELD_BITS+7)/8)*8-1:0]       in_tdata,   // x_coord
  input  wire logic                                  in_tuser,   // restart_count
  // result items
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [((3*FIELD_BITS+8)/8)*8-1:0]          out_tdata,  // point_x, point_y,
                                                                 // point_index
  output logic                                       out_tlast,  // last
  // configuration writes
  input  wire logic                                  cfg_we,
  input  wire logic [ecps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [FIELD_BITS-1:0]                 cfg_wdata
);

  import ecps_pkg::*;

  localparam int W      = FIELD_BITS;
  localparam int CW     = W + 1;                      // point index width
  localparam int OUT_DW = ((3 * W + 8) / 8) * 8;
  localparam int OUT_FW = 3 * W + 1;
  localparam int CNT_W  = (W > 1) ? $clog2(W) : 1;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_MUL   = 6'b000100,
    S_ADD   = 6'b001000,
    S_SRCH  = 6'b010000,
    S_EMIT0 = 6'b100000
  } state_t;

  // operations run through the shared unit in S_LOAD / S_MUL
  typedef enum logic [2:0] {
    OP_RED_X = 3'd0,   // x mod p
    OP_RED_A = 3'd1,   // a mod p
    OP_RED_B = 3'd2,   // b mod p
    OP_MUL_AX = 3'd3,  // a*x mod p
    OP_MUL_XX = 3'd4,  // x*x mod p
    OP_MUL_RX = 3'd5   // (x*x)*x mod p
  } op_t;

  // configuration registers
  logic [W-1:0]     curve_a_r, curve_b_r, prime_r;

  // control
  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             add_ph_r, add_ph_nxt;
  logic             second_r, second_nxt;     // second point still to send
  logic [CW-1:0]    count_r, count_nxt;

  // datapath
  logic [W-1:0]     x_raw_r, x_raw_nxt;
  logic [W-1:0]     opnd_r, opnd_nxt;
  logic [W-1:0]     acc_r, acc_nxt;
  logic [W-1:0]     x_r, x_nxt;
  logic [W-1:0]     a_r, a_nxt;
  logic [W-1:0]     b_r, b_nxt;
  logic [W-1:0]     r_r, r_nxt;
  logic [W-1:0]     d_r, d_nxt;               // (2y + 1) mod p
  logic [W-1:0]     y_r, y_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_FW-1:0]    out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;

  // shared modular unit: ((dbl ? 2*acc : acc) + (add ? addend : 0)) mod p
  logic             u_dbl, u_add;
  logic [W-1:0]     u_in, u_addend, u_out;
  logic [W:0]       u_t1, u_t1r, u_t2;

  always_comb begin
    u_t1  = u_dbl ? {u_in, 1'b0} : {1'b0, u_in};
    u_t1r = (u_t1 >= {1'b0, prime_r}) ? u_t1 - {1'b0, prime_r} : u_t1;
    u_t2  = u_t1r + (u_add ? {1'b0, u_addend} : '0);
    u_out = (u_t2 >= {1'b0, prime_r}) ? W'(u_t2 - {1'b0, prime_r}) : W'(u_t2);
  end

  // side values for the search and the points
  logic [W:0]   d_sum;
  logic [W-1:0] d_step;
  logic [W-1:0] opp_y;
  logic         hit, y_end, mul_done;
  logic         in_acc, out_free;

  assign d_sum    = {1'b0, d_r} + (W+1)'(2);
  assign d_step   = (d_sum >= {1'b0, prime_r}) ? W'(d_sum - {1'b0, prime_r}) : W'(d_sum);
  assign opp_y    = (y_r == '0) ? '0 : prime_r - y_r;
  assign hit      = (acc_r == r_r);
  assign y_end    = (y_r == prime_r - W'(1));
  assign mul_done = (cnt_r == CNT_W'(W - 1));
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(out_data_r);
  assign out_tlast  = out_last_r;

  // unit operand selection
  always_comb begin
    u_in     = acc_r;
    u_dbl    = 1'b0;
    u_add    = 1'b1;
    u_addend = d_r;
    unique case (state_r)
      S_MUL: begin
        u_dbl = 1'b1;
        u_add = opnd_r[W-1];
        unique case (op_r)
          OP_MUL_AX:            u_addend = a_r;
          OP_MUL_XX, OP_MUL_RX: u_addend = x_r;
          default:              u_addend = W'(1);
        endcase
      end
      S_ADD:   u_addend = add_ph_r ? b_r : r_r;
      default: u_addend = d_r;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    add_ph_nxt    = add_ph_r;
    second_nxt    = second_r;
    count_nxt     = count_r;
    x_raw_nxt     = x_raw_r;
    opnd_nxt      = opnd_r;
    acc_nxt       = acc_r;
    x_nxt         = x_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    r_nxt         = r_r;
    d_nxt         = d_r;
    y_nxt         = y_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          x_raw_nxt = in_tdata[W-1:0];
          if (in_tuser) count_nxt = '0;
          op_nxt = OP_RED_X;
          // a zero modulus gives no point
          if (prime_r != '0) state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        unique case (op_r)
          OP_RED_X:             opnd_nxt = x_raw_r;
          OP_RED_A:             opnd_nxt = curve_a_r;
          OP_RED_B:             opnd_nxt = curve_b_r;
          OP_MUL_AX, OP_MUL_XX: opnd_nxt = x_r;
          default:              opnd_nxt = acc_r;   // x*x from the step before
        endcase
        if (op_r == OP_MUL_RX) acc_nxt = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        acc_nxt  = u_out;
        opnd_nxt = {opnd_r[W-2:0], 1'b0};
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (mul_done) begin
          unique case (op_r)
            OP_RED_X:  x_nxt = u_out;
            OP_RED_A:  a_nxt = u_out;
            OP_RED_B:  b_nxt = u_out;
            OP_MUL_AX: r_nxt = u_out;
            default: ;
          endcase
          if (op_r == OP_MUL_RX) begin
            add_ph_nxt = 1'b0;
            state_nxt  = S_ADD;
          end else begin
            op_nxt    = op_t'(op_r + 3'd1);
            state_nxt = S_LOAD;
          end
        end
      end
      S_ADD: begin
        if (!add_ph_r) begin
          acc_nxt    = u_out;          // x^3 + a*x
          add_ph_nxt = 1'b1;
        end else begin
          r_nxt     = u_out;           // + b
          acc_nxt   = '0;              // y*y for y = 0
          d_nxt     = W'(1);
          y_nxt     = '0;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (hit) begin
          second_nxt = 1'b0;
          state_nxt  = S_EMIT0;
        end else if (y_end) begin
          state_nxt = S_IDLE;
        end else begin
          acc_nxt = u_out;
          d_nxt   = d_step;
          y_nxt   = y_r + W'(1);
        end
      end
      S_EMIT0: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          count_nxt     = count_r + CW'(1);
          if (!second_r) begin
            out_data_nxt = {count_r, y_r, x_r};
            out_last_nxt = (opp_y == y_r);
            second_nxt   = 1'b1;
            if (opp_y == y_r) state_nxt = S_IDLE;
          end else begin
            out_data_nxt = {count_r, opp_y, x_r};
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_RED_X;
      cnt_r       <= '0;
      add_ph_r    <= 1'b0;
      second_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      curve_a_r   <= '0;
      curve_b_r   <= '0;
      prime_r     <= W'(PRIME_RESET);
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      add_ph_r    <= add_ph_nxt;
      second_r    <= second_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CURVE_A: curve_a_r <= cfg_wdata;
          REG_CURVE_B: curve_b_r <= cfg_wdata;
          REG_PRIME:   prime_r   <= cfg_wdata;
          default: ;   // unused index
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_raw_r    <= x_raw_nxt;
    opnd_r     <= opnd_nxt;
    acc_r      <= acc_nxt;
    x_r        <= x_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    r_r        <= r_nxt;
    d_r        <= d_nxt;
    y_r        <= y_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // the y walk never runs past p - 1 and keeps y*y reduced
  `ECPS_ASSERT_IMP(a_srch_range, state_r == S_SRCH, (y_r < prime_r) && (acc_r < prime_r), "search value out of field range")
  // a second point is only sent for a nonzero root
  `ECPS_ASSERT_IMP(a_second_nonzero, (state_r == S_EMIT0) && second_r, y_r != '0, "second point for zero root")
  // a search hit is followed by the first point of the item
  `ECPS_ASSERT_NEXT(a_hit_emit, (state_r == S_SRCH) && hit, (state_r == S_EMIT0) && !second_r, "search hit not followed by point output")

endmodule

`default_nettype wire
